@@ hdl/ctp_pkg.sv @@
// Shared constants, result codes and stage types for the caption timestamp parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ctp_pkg;

  // field widths
  localparam int HOUR_BITS = 20;
  localparam int CP_W      = 21;
  localparam int STATUS_W  = 3;
  localparam int MS_W      = 42;
  localparam int CHARS_W   = 5;
  localparam int MINSEC_W  = 7;
  localparam int MILLI_W   = 10;
  localparam int LOW_W     = 22;
  localparam int PH_W      = 3;

  // character codes
  localparam logic [CP_W-1:0] CP_ZERO  = 21'h30;
  localparam logic [CP_W-1:0] CP_NINE  = 21'h39;
  localparam logic [CP_W-1:0] CP_COLON = 21'h3A;
  localparam logic [CP_W-1:0] CP_STOP  = 21'h2E;

  // limits and scale factors
  localparam logic [HOUR_BITS-1:0] HOUR_MAX     = '1;
  localparam logic [CHARS_W-1:0]   COUNT_MAX    = '1;
  localparam logic [MINSEC_W-1:0]  MINUTE_LIMIT = 7'd60;
  localparam logic [LOW_W-1:0]     MS_PER_HOUR  = 22'd3600000;
  localparam logic [LOW_W-1:0]     MS_PER_MIN   = 22'd60000;
  localparam logic [LOW_W-1:0]     MS_PER_SEC   = 22'd1000;

  // parser phases
  localparam logic [PH_W-1:0] PH_START  = 3'd0;
  localparam logic [PH_W-1:0] PH_FIRST  = 3'd1;
  localparam logic [PH_W-1:0] PH_SECOND = 3'd2;
  localparam logic [PH_W-1:0] PH_THIRD  = 3'd3;
  localparam logic [PH_W-1:0] PH_MILLI  = 3'd4;
  localparam logic [PH_W-1:0] PH_DONE   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FIRST = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_COLON  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIGITS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_STOP   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EARLY_END = 3'd6;

  // parsed timestamp handed from the parser to the time adder
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HOUR_BITS-1:0] hours;
    logic [MINSEC_W-1:0]  minutes;
    logic [MINSEC_W-1:0]  seconds;
    logic [MILLI_W-1:0]   millis;
    logic [CHARS_W-1:0]   chars;
  } ctp_fields_t;

  // saturating run counter
  function automatic logic [CHARS_W-1:0] sat_inc(input logic [CHARS_W-1:0] v);
    return (v < COUNT_MAX) ? v + 1'b1 : COUNT_MAX;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ctp_if.sv @@
// Valid/ready channel interfaces for the character input and the timestamp result.
// Depends on ctp_pkg for payload widths.
`default_nettype none

interface ctp_in_if import ctp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface ctp_out_if import ctp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [MS_W-1:0]     total_ms;
  logic [CHARS_W-1:0]  chars_used;

  modport source (output valid, output status, output total_ms, output chars_used,
                  input ready);
  modport sink   (input valid, input status, input total_ms, input chars_used,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/ctp_parse.sv @@
// Character input register, timestamp parser state and parsed-result register.
// Depends on ctp_pkg; feeds ctp_time.
`default_nettype none

module ctp_parse import ctp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CP_W-1:0] in_code_point,
  input  wire logic            in_end_of_text,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output ctp_fields_t          res_fields
);

  // input register
  logic            a_v_r;
  logic [CP_W-1:0] a_cp_r;
  logic            a_eot_r;

  // parser state
  logic [PH_W-1:0]      phase_r, phase_nxt;
  logic [HOUR_BITS-1:0] first_r, first_nxt;
  logic [MINSEC_W-1:0]  second_r, second_nxt;
  logic [MINSEC_W-1:0]  third_r, third_nxt;
  logic [MILLI_W-1:0]   milli_r, milli_nxt;
  logic [CHARS_W-1:0]   dcount_r, dcount_nxt;
  logic [CHARS_W-1:0]   fdigits_r, fdigits_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CHARS_W-1:0]   used_r, used_nxt;

  // parsed-result register
  logic        b_v_r;
  ctp_fields_t b_r, b_nxt;

  logic                   hit;
  logic                   a_adv;
  logic                   digit;
  logic [3:0]             dval;
  logic [HOUR_BITS+3:0]   first_wide;
  logic                   hours_form;

  // handshakes: an item with no result never waits on the result register
  assign a_adv    = a_v_r && (!hit || !b_v_r || res_ready);
  assign in_ready = !a_v_r || a_adv;

  assign digit = !a_eot_r && (a_cp_r >= CP_ZERO) && (a_cp_r <= CP_NINE);
  assign dval  = a_cp_r[3:0];

  // first field times ten plus digit, wide enough to see the hour limit
  assign first_wide = ({4'd0, first_r} << 3) + ({4'd0, first_r} << 1)
                      + (HOUR_BITS+4)'(dval);
  assign hours_form = (fdigits_r != 5'd2) || (first_r >= HOUR_BITS'(MINUTE_LIMIT)) || ovf_r;

  // one parser step per character
  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    third_nxt   = third_r;
    milli_nxt   = milli_r;
    dcount_nxt  = dcount_r;
    fdigits_nxt = fdigits_r;
    ovf_nxt     = ovf_r;
    used_nxt    = used_r;
    hit         = 1'b0;
    b_nxt       = '0;
    b_nxt.chars = used_r;

    case (phase_r)
      PH_START: begin
        if (a_eot_r) begin
          hit          = 1'b1;
          b_nxt.status = ST_EARLY_END;
        end else if (!digit) begin
          hit          = 1'b1;
          b_nxt.status = ST_BAD_FIRST;
        end else begin
          first_nxt   = HOUR_BITS'(dval);
          fdigits_nxt = 5'd1;
          phase_nxt   = PH_FIRST;
          used_nxt    = sat_inc(used_r);
        end
      end
      PH_FIRST: begin
        if (digit) begin
          if (first_wide > (HOUR_BITS+4)'(HOUR_MAX)) begin
            first_nxt = HOUR_MAX;
            ovf_nxt   = 1'b1;
          end else begin
            first_nxt = first_wide[HOUR_BITS-1:0];
          end
          fdigits_nxt = sat_inc(fdigits_r);
          used_nxt    = sat_inc(used_r);
        end else if (a_eot_r) begin
          hit          = 1'b1;
          b_nxt.status = ST_EARLY_END;
        end else if (a_cp_r != CP_COLON) begin
          hit          = 1'b1;
          b_nxt.status = ST_NO_COLON;
        end else begin
          dcount_nxt = '0;
          phase_nxt  = PH_SECOND;
          used_nxt   = sat_inc(used_r);
        end
      end
      PH_SECOND, PH_THIRD: begin
        if (digit) begin
          if (dcount_r < 5'd2) begin
            if (phase_r == PH_SECOND) begin
              second_nxt = (second_r << 3) + (second_r << 1) + MINSEC_W'(dval);
            end else begin
              third_nxt = (third_r << 3) + (third_r << 1) + MINSEC_W'(dval);
            end
          end
          dcount_nxt = sat_inc(dcount_r);
          used_nxt   = sat_inc(used_r);
        end else if (dcount_r != 5'd2) begin
          hit          = 1'b1;
          b_nxt.status = ST_DIGITS;
        end else if (a_eot_r) begin
          hit          = 1'b1;
          b_nxt.status = ST_EARLY_END;
        end else if (phase_r == PH_SECOND) begin
          if (a_cp_r == CP_COLON) begin
            phase_nxt  = PH_THIRD;
            dcount_nxt = '0;
            used_nxt   = sat_inc(used_r);
          end else if (hours_form) begin
            hit          = 1'b1;
            b_nxt.status = ST_NO_COLON;
          end else if (a_cp_r == CP_STOP) begin
            // short form: first field was minutes, no hours
            third_nxt  = second_r;
            second_nxt = first_r[MINSEC_W-1:0];
            first_nxt  = '0;
            phase_nxt  = PH_MILLI;
            dcount_nxt = '0;
            used_nxt   = sat_inc(used_r);
          end else begin
            hit          = 1'b1;
            b_nxt.status = ST_NO_STOP;
          end
        end else if (a_cp_r != CP_STOP) begin
          hit          = 1'b1;
          b_nxt.status = ST_NO_STOP;
        end else begin
          phase_nxt  = PH_MILLI;
          dcount_nxt = '0;
          used_nxt   = sat_inc(used_r);
        end
      end
      PH_MILLI: begin
        if (digit) begin
          if (dcount_r < 5'd3) begin
            milli_nxt = (milli_r << 3) + (milli_r << 1) + MILLI_W'(dval);
          end
          dcount_nxt = sat_inc(dcount_r);
          used_nxt   = sat_inc(used_r);
        end else if (dcount_r != 5'd3) begin
          hit          = 1'b1;
          b_nxt.status = ST_DIGITS;
        end else if (ovf_r || (second_r >= MINUTE_LIMIT) || (third_r >= MINUTE_LIMIT)) begin
          hit          = 1'b1;
          b_nxt.status = ST_RANGE;
        end else begin
          hit           = 1'b1;
          b_nxt.status  = ST_OK;
          b_nxt.hours   = first_r;
          b_nxt.minutes = second_r;
          b_nxt.seconds = third_r;
          b_nxt.millis  = milli_r;
        end
      end
      default: begin
      end
    endcase

    // a result without end of text parks the parser until end of text
    if (hit && !a_eot_r) begin
      phase_nxt = PH_DONE;
    end
    // end of text always returns to the reset state
    if (a_eot_r) begin
      phase_nxt   = PH_START;
      first_nxt   = '0;
      second_nxt  = '0;
      third_nxt   = '0;
      milli_nxt   = '0;
      dcount_nxt  = '0;
      fdigits_nxt = '0;
      ovf_nxt     = 1'b0;
      used_nxt    = '0;
    end
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      phase_r   <= PH_START;
      first_r   <= '0;
      second_r  <= '0;
      third_r   <= '0;
      milli_r   <= '0;
      dcount_r  <= '0;
      fdigits_r <= '0;
      ovf_r     <= 1'b0;
      used_r    <= '0;
    end else begin
      if (in_ready) begin
        a_v_r <= in_valid;
      end
      if (a_adv && hit) begin
        b_v_r <= 1'b1;
      end else if (res_ready) begin
        b_v_r <= 1'b0;
      end
      if (a_adv) begin
        phase_r   <= phase_nxt;
        first_r   <= first_nxt;
        second_r  <= second_nxt;
        third_r   <= third_nxt;
        milli_r   <= milli_nxt;
        dcount_r  <= dcount_nxt;
        fdigits_r <= fdigits_nxt;
        ovf_r     <= ovf_nxt;
        used_r    <= used_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_cp_r  <= in_code_point;
      a_eot_r <= in_end_of_text;
    end
    if (a_adv && hit) begin
      b_r <= b_nxt;
    end
  end

  assign res_valid  = b_v_r;
  assign res_fields = b_r;

`ifndef SYNTHESIS
  // a finished step always lands in the result register
  a_hit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && hit) |=> b_v_r)
    else $error("parsed result lost");

  // a stalled result holds its value
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !res_ready) |=> (b_v_r && $stable(b_r)))
    else $error("parsed result changed while stalled");

  // an ok result carries in-range minutes and seconds
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && (b_r.status == ST_OK)) |->
      ((b_r.minutes < MINUTE_LIMIT) && (b_r.seconds < MINUTE_LIMIT)))
    else $error("ok result out of range");

  // an error result carries no time
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && (b_r.status != ST_OK)) |->
      ((b_r.hours == '0) && (b_r.minutes == '0) && (b_r.seconds == '0)
       && (b_r.millis == '0)))
    else $error("error result carries a time");
`endif

endmodule

`default_nettype wire

@@ hdl/ctp_time.sv @@
// Millisecond arithmetic: hour product and minor sum in one stage, final add in the output register.
// Depends on ctp_pkg; takes parsed fields from ctp_parse.
`default_nettype none

module ctp_time import ctp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  output logic                     res_ready,
  input  wire ctp_fields_t         res_fields,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [MS_W-1:0]          out_total_ms,
  output logic [CHARS_W-1:0]       out_chars_used
);

  localparam int PROD_W = HOUR_BITS + LOW_W;

  // product stage
  logic                c_v_r;
  logic [STATUS_W-1:0] c_status_r;
  logic [CHARS_W-1:0]  c_chars_r;
  logic [MS_W-1:0]     c_hours_ms_r, c_hours_ms_nxt;
  logic [LOW_W-1:0]    c_low_r, c_low_nxt;

  // output register
  logic                o_v_r;
  logic [STATUS_W-1:0] o_status_r;
  logic [MS_W-1:0]     o_total_r;
  logic [CHARS_W-1:0]  o_chars_r;

  logic                   c_adv;
  logic                   o_load;
  logic [PROD_W-1:0]      hours_prod;
  logic [PROD_W+MS_W-1:0] hours_prod_ext;

  assign o_load    = !o_v_r || out_ready;
  assign c_adv     = c_v_r && o_load;
  assign res_ready = !c_v_r || c_adv;

  // hours times ms per hour, wrapped to the result width
  assign hours_prod     = PROD_W'(res_fields.hours) * PROD_W'(MS_PER_HOUR);
  assign hours_prod_ext = (PROD_W+MS_W)'(hours_prod);
  assign c_hours_ms_nxt = hours_prod_ext[MS_W-1:0];

  // minutes, seconds and millis stay below one hour
  assign c_low_nxt = LOW_W'(res_fields.minutes) * MS_PER_MIN
                     + LOW_W'(res_fields.seconds) * MS_PER_SEC
                     + LOW_W'(res_fields.millis);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (res_ready) begin
        c_v_r <= res_valid;
      end
      if (o_load) begin
        o_v_r <= c_v_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      c_status_r   <= res_fields.status;
      c_chars_r    <= res_fields.chars;
      c_hours_ms_r <= c_hours_ms_nxt;
      c_low_r      <= c_low_nxt;
    end
    if (c_adv) begin
      o_status_r <= c_status_r;
      o_chars_r  <= c_chars_r;
      o_total_r  <= c_hours_ms_r + MS_W'(c_low_r);
    end
  end

  assign out_valid      = o_v_r;
  assign out_status     = o_status_r;
  assign out_total_ms   = o_total_r;
  assign out_chars_used = o_chars_r;

endmodule

`default_nettype wire

@@ hdl/caption_timestamp_parser.sv @@
// Caption timestamp parser top level: channel interfaces around parser and time adder.
// Depends on ctp_pkg, ctp_if, ctp_parse and ctp_time.
//
// Usage:
//   in_bus carries one character beat per item: a 21-bit code point, or an
//   end_of_text flag that closes the current text. Text of the form
//   mm:ss.ttt or hh:mm:ss.ttt is recognized; out_bus carries one beat per
//   timestamp with a status code, the time in milliseconds (zero unless ok)
//   and the count of characters used.
//   A result is raised by the character after the millisecond digits, by
//   end of text, or by the first error; later characters are dropped until
//   end of text, which always returns the parser to its start.
//   Throughput is one character per cycle while no result is stalled. A result
//   beat passes the input register, the parse register and the hour product
//   register, then the output register, before it appears on out_bus.
//   Reset (rst_n low, synchronous) empties all stages and restarts parsing.
//   When out_bus stalls, the product stage and the parse register still
//   fill, and characters that produce no result keep flowing; in_bus.ready
//   drops only once a result has nowhere to go.
`default_nettype none

module caption_timestamp_parser import ctp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ctp_in_if.sink    in_bus,
  ctp_out_if.source out_bus
);

  logic        res_valid;
  logic        res_ready;
  ctp_fields_t res_fields;

  // character parser
  ctp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_bus.valid),
    .in_ready       (in_bus.ready),
    .in_code_point  (in_bus.code_point),
    .in_end_of_text (in_bus.end_of_text),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_fields     (res_fields)
  );

  // millisecond total
  ctp_time u_time (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_fields     (res_fields),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_status     (out_bus.status),
    .out_total_ms   (out_bus.total_ms),
    .out_chars_used (out_bus.chars_used)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for caption_timestamp_parser: character beats in, one result per text out.
// Depends on ctp_pkg, ctp_if and the caption_timestamp_parser RTL.
// An in-bench parser predicts every result; a monitor compares each result beat field by field.
`default_nettype none

module tb_top;
  import ctp_pkg::*;

  localparam logic [CP_W-1:0] CP_TOP      = 21'h10FFFF;
  localparam int unsigned     CYCLE_LIMIT = 200000;
  localparam int unsigned     HOLD_CYCLES = 300;
  localparam int unsigned     TAIL_CYCLES = 12;
  localparam int unsigned     PRINT_MAX   = 40;

  // one expected result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MS_W-1:0]     total_ms;
    logic [CHARS_W-1:0]  chars_used;
  } stamp_t;

  logic clk = 1'b0;
  logic rst_n;

  ctp_in_if  in_bus ();
  ctp_out_if out_bus ();

  caption_timestamp_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench-side parser state
  logic [PH_W-1:0]      parse_phase = PH_START;
  logic [HOUR_BITS-1:0] lead_val    = '0;
  logic [MINSEC_W-1:0]  mid_val     = '0;
  logic [MINSEC_W-1:0]  tail_val    = '0;
  logic [MILLI_W-1:0]   frac_val    = '0;
  logic [CHARS_W-1:0]   run_len     = '0;
  logic [CHARS_W-1:0]   lead_len    = '0;
  logic                 hour_ovf    = 1'b0;
  logic [CHARS_W-1:0]   used_cnt    = '0;

  stamp_t          expected_stamps[$];
  logic [CP_W-1:0] text_buf[$];

  int unsigned err_cnt        = 0;
  int unsigned chars_sent     = 0;
  int unsigned texts_sent     = 0;
  int unsigned stamps_checked = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned status_seen[8];

  bit idle_en     = 1'b0;
  bit hold_active = 1'b0;
  int hold_kick   = 0;

  // mismatch report: one line each, printing capped
  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_MAX) $display("tb_top: mismatch: %s", msg);
  endtask

  function automatic logic [CHARS_W-1:0] bump(input logic [CHARS_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_START;
    lead_val    = '0;
    mid_val     = '0;
    tail_val    = '0;
    frac_val    = '0;
    run_len     = '0;
    lead_len    = '0;
    hour_ovf    = 1'b0;
    used_cnt    = '0;
  endfunction

  // queue a result, then either restart or drop input until end of text
  function automatic void emit_stamp(input logic [STATUS_W-1:0] st, input logic [MS_W-1:0] ms,
                                     input logic eot);
    stamp_t s;
    s.status     = st;
    s.total_ms   = ms;
    s.chars_used = used_cnt;
    expected_stamps.insert(expected_stamps.size(), s);
    status_seen[st]++;
    if (eot) clear_parse();
    else parse_phase = PH_DONE;
  endfunction

  // separator taken: next digit run starts
  function automatic void take_separator(input logic [PH_W-1:0] nxt);
    parse_phase = nxt;
    run_len     = '0;
    used_cnt    = bump(used_cnt);
  endfunction

  // predict the effect of one accepted character beat
  function automatic void parse_char(input logic [CP_W-1:0] cp, input logic eot);
    logic            is_dig;
    logic [3:0]      d;
    logic            hours;
    longint unsigned ms;
    is_dig = !eot && (cp >= CP_ZERO) && (cp <= CP_NINE);
    d      = is_dig ? 4'(cp - CP_ZERO) : 4'd0;
    hours  = (lead_len != 2) || (lead_val >= HOUR_BITS'(MINUTE_LIMIT)) || hour_ovf;
    case (parse_phase)
      PH_START: begin
        if (eot) emit_stamp(ST_EARLY_END, '0, 1'b1);
        else if (!is_dig) emit_stamp(ST_BAD_FIRST, '0, 1'b0);
        else begin
          lead_val    = HOUR_BITS'(d);
          lead_len    = 1;
          parse_phase = PH_FIRST;
          used_cnt    = bump(used_cnt);
        end
      end
      PH_FIRST: begin
        if (is_dig) begin
          // hours saturate instead of wrapping
          if (64'(lead_val) > (64'(HOUR_MAX) - 64'(d)) / 10) begin
            lead_val = HOUR_MAX;
            hour_ovf = 1'b1;
          end else begin
            lead_val = HOUR_BITS'(64'(lead_val) * 10 + 64'(d));
          end
          lead_len = bump(lead_len);
          used_cnt = bump(used_cnt);
        end else if (eot) emit_stamp(ST_EARLY_END, '0, 1'b1);
        else if (cp != CP_COLON) emit_stamp(ST_NO_COLON, '0, 1'b0);
        else take_separator(PH_SECOND);
      end
      PH_SECOND, PH_THIRD: begin
        if (is_dig) begin
          if (run_len < 2) begin
            if (parse_phase == PH_SECOND) mid_val = MINSEC_W'(mid_val * 10 + d);
            else tail_val = MINSEC_W'(tail_val * 10 + d);
          end
          run_len  = bump(run_len);
          used_cnt = bump(used_cnt);
        end else if (run_len != 2) emit_stamp(ST_DIGITS, '0, eot);
        else if (eot) emit_stamp(ST_EARLY_END, '0, 1'b1);
        else if (parse_phase == PH_SECOND && cp == CP_COLON) take_separator(PH_THIRD);
        else if (parse_phase == PH_SECOND && hours) emit_stamp(ST_NO_COLON, '0, 1'b0);
        else if (parse_phase == PH_SECOND && cp == CP_STOP) begin
          // short form: fields shift down to minutes and seconds
          tail_val = mid_val;
          mid_val  = MINSEC_W'(lead_val);
          lead_val = '0;
          take_separator(PH_MILLI);
        end else if (parse_phase == PH_THIRD && cp == CP_STOP) take_separator(PH_MILLI);
        else emit_stamp(ST_NO_STOP, '0, 1'b0);
      end
      PH_MILLI: begin
        if (is_dig) begin
          if (run_len < 3) frac_val = MILLI_W'(frac_val * 10 + d);
          run_len  = bump(run_len);
          used_cnt = bump(used_cnt);
        end else if (run_len != 3) emit_stamp(ST_DIGITS, '0, eot);
        else if (hour_ovf || mid_val >= MINUTE_LIMIT || tail_val >= MINUTE_LIMIT)
          emit_stamp(ST_RANGE, '0, eot);
        else begin
          ms = 64'(lead_val) * 64'(MS_PER_HOUR) + 64'(mid_val) * 64'(MS_PER_MIN)
             + 64'(tail_val) * 64'(MS_PER_SEC) + 64'(frac_val);
          emit_stamp(ST_OK, MS_W'(ms), eot);
        end
      end
      default: begin
        if (eot) clear_parse();
      end
    endcase
  endfunction

  // monitor: check the result beat first, then predict from the character beat
  always @(posedge clk) begin : watch_beats
    stamp_t want;
    if (rst_n === 1'b1) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_stamps.size() == 0) begin
          flag_error($sformatf("result with none pending, status %0d", out_bus.status));
        end else begin
          want = expected_stamps.pop_front();
          if (out_bus.status !== want.status)
            flag_error($sformatf("status %0d, expected %0d", out_bus.status, want.status));
          if (out_bus.total_ms !== want.total_ms)
            flag_error($sformatf("total_ms %0d, expected %0d", out_bus.total_ms,
                                 want.total_ms));
          if (out_bus.chars_used !== want.chars_used)
            flag_error($sformatf("chars_used %0d, expected %0d", out_bus.chars_used,
                                 want.chars_used));
          stamps_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) parse_char(in_bus.code_point, in_bus.end_of_text);
    end
  end

  // long receiver hold-off, started by a kick from the test sequence
  initial begin : hold_counter
    int unsigned left;
    int          seen;
    left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (left != 0) left--;
      else if (hold_kick != seen) begin
        seen = hold_kick;
        left = HOLD_CYCLES;
      end
      hold_active <= (left != 0);
    end
  end

  // result receiver with random stalls
  initial begin : result_sink
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= hold_active ? 1'b0 : (!idle_en || $urandom_range(99) >= 37);
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // offer one character beat and wait until it is taken
  task automatic send_char(input logic [CP_W-1:0] cp, input logic eot);
    if (idle_en && $urandom_range(99) < 37) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_bus.valid       <= 1'b1;
    in_bus.code_point  <= cp;
    in_bus.end_of_text <= eot;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    chars_sent++;
  endtask

  // send the buffered text followed by end of text
  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], 1'b0);
    send_char(CP_W'($urandom_range(0, CP_TOP)), 1'b1);
    text_buf.delete();
    texts_sent++;
  endtask

  // lower valid and wait for every pending result
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_stamps.size() != 0);
  endtask

  // append one character to the text under construction
  function automatic void add_cp(input logic [CP_W-1:0] cp);
    text_buf.insert(text_buf.size(), cp);
  endfunction

  function automatic void put_str(input string s);
    foreach (s[i]) add_cp(CP_W'(s[i]));
  endfunction

  task automatic run_text(input string s);
    put_str(s);
    send_text();
  endtask

  function automatic logic [CP_W-1:0] pick_cp();
    case ($urandom_range(5))
      0:       return CP_ZERO + CP_W'($urandom_range(9));
      1:       return CP_COLON;
      2:       return CP_STOP;
      3:       return CP_W'($urandom_range(127));
      4:       return CP_W'($urandom_range(0, CP_TOP));
      default: begin
        case ($urandom_range(3))
          0:       return 21'h2F;
          1:       return 21'h3B;
          2:       return 21'h0;
          default: return CP_TOP;
        endcase
      end
    endcase
  endfunction

  function automatic void add_digit(input int lo, input int hi);
    add_cp(CP_ZERO + CP_W'($urandom_range(lo, hi)));
  endfunction

  // two-digit field, mostly below sixty
  function automatic void add_pair();
    if ($urandom_range(99) < 85) add_digit(0, 5);
    else add_digit(6, 9);
    add_digit(0, 9);
  endfunction

  // mostly well-formed timestamp with random content and an optional random trailer
  function automatic void build_stamp();
    int n;
    if ($urandom_range(1) == 1) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
      repeat (n) add_digit(0, 9);
      add_cp(CP_COLON);
    end
    add_pair();
    add_cp(CP_COLON);
    add_pair();
    add_cp(CP_STOP);
    n = ($urandom_range(19) == 0) ? $urandom_range(0, 5) : 3;
    repeat (n) add_digit(0, 9);
    case ($urandom_range(3))
      2: add_cp(pick_cp());
      3: repeat ($urandom_range(1, 4)) add_cp(pick_cp());
      default: ;
    endcase
  endfunction

  // one edit: replace, delete, insert a char or insert a digit run
  function automatic void mutate_text();
    int p;
    if (text_buf.size() == 0) return;
    p = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(3))
      0: text_buf[p] = pick_cp();
      1: text_buf.delete(p);
      2: text_buf.insert(p, pick_cp());
      default: begin
        repeat ($urandom_range(1, 35)) text_buf.insert(p, CP_ZERO + CP_W'($urandom_range(9)));
      end
    endcase
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(0, 6)) add_cp(pick_cp());
  endfunction

  // mix of good, edited and noise texts until the character budget is spent
  task automatic send_mixed(input int unsigned budget);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 70) build_stamp();
      else if (roll < 90) begin
        build_stamp();
        mutate_text();
      end else add_noise();
      send_text();
    end
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // extremes and every error path
  task automatic test_directed();
    idle_en <= 1'b1;
    send_text();                             // empty text
    add_cp(CP_TOP);                          // top code point as first char
    run_text("00:00.000");
    put_str("59:59.999");                    // terminator of value zero, then ignored input
    add_cp('0);
    run_text("7");
    run_text("1048575:59:59.999");           // largest time
    run_text("1048576:00:00.000");           // hours beyond the bound
    run_text("00:60.000");                   // seconds out of range
    run_text("00:00:00.000");
    run_text("60:00.000");                   // first field is hours, stop where colon due
    run_text("12:3");                        // short run before end of text
    run_text("12:34");                       // end where full stop due
    run_text("7");
    run_text("00;");
    run_text("00:00x");
    run_text("00:00:00x");
    put_str("00:00.");                       // very long millisecond run
    repeat (34) add_cp(CP_ZERO);
    send_text();
    drain();
  endtask

  task automatic test_random_traffic();
    idle_en <= 1'b1;
    send_mixed(1100);
    drain();
  endtask

  // no idling on either side
  task automatic test_steady_stream();
    idle_en <= 1'b0;
    send_mixed(400);
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    idle_en   <= 1'b0;
    hold_kick <= hold_kick + 1;
    repeat (30) begin
      build_stamp();
      send_text();
    end
    drain();
    idle_en <= 1'b1;
  endtask

  initial begin : sequence_main
    in_bus.valid       <= 1'b0;
    in_bus.code_point  <= '0;
    in_bus.end_of_text <= 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    apply_reset();
    test_directed();
    test_random_traffic();
    test_steady_stream();
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_stamps.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_stamps.size()));
    $display("tb_top: %0d texts, %0d characters, %0d results checked, %0d mismatches",
             texts_sent, chars_sent, stamps_checked, err_cnt);
    $display("tb_top: mix ok %0d, first %0d, colon %0d, digits %0d, stop %0d, range %0d, end %0d",
             status_seen[ST_OK], status_seen[ST_BAD_FIRST], status_seen[ST_NO_COLON],
             status_seen[ST_DIGITS], status_seen[ST_NO_STOP], status_seen[ST_RANGE],
             status_seen[ST_EARLY_END]);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
